// ----- hdl/avr_pkg.sv -----
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants for the axis vector rotation unit
// Holds the beat formats, fixed-point constants and the CORDIC arctangent
// table.
// ----------------------------------------------------------------------------
package avr_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 30;

    // CORDIC datapath widths: x/y in Q2.30 with headroom, z in Q3.28.
    localparam int XY_WIDTH = 34;
    localparam int Z_WIDTH  = 32;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [XY_WIDTH-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [XY_WIDTH-1:0] ONE_Q30  = 34'sd1073741824;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic [1:0]                     req_type;
        logic signed [COORD_WIDTH-1:0]  coord_x;
        logic signed [COORD_WIDTH-1:0]  coord_y;
        logic signed [COORD_WIDTH-1:0]  coord_z;
        logic signed [ANGLE_WIDTH-1:0]  turn_angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rot_x;
        logic signed [COORD_WIDTH-1:0] rot_y;
        logic signed [COORD_WIDTH-1:0] rot_z;
    } t_out_beat;

    // atan(2^-i) in Q28, rounded to nearest.
    function automatic logic signed [Z_WIDTH-1:0] atan_q28(input int idx);
        logic signed [Z_WIDTH-1:0] v;
        case (idx)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459457;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            24: v = 32'sd16;
            25: v = 32'sd8;
            26: v = 32'sd4;
            27: v = 32'sd2;
            28: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/avr_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// avr_cordic_stage: one registered CORDIC rotation-mode iteration
// Applies the shift-add micro-rotation for step STEP and carries the
// beat sideband alongside.
// ----------------------------------------------------------------------------
module avr_cordic_stage
    import avr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [XY_WIDTH-1:0] i_x,
    input  logic signed [XY_WIDTH-1:0] i_y,
    input  logic signed [Z_WIDTH-1:0]  i_z,
    input  logic                       i_neg,
    input  t_in_beat                   i_beat,
    output logic                       o_vld,
    output logic signed [XY_WIDTH-1:0] o_x,
    output logic signed [XY_WIDTH-1:0] o_y,
    output logic signed [Z_WIDTH-1:0]  o_z,
    output logic                       o_neg,
    output t_in_beat                   o_beat
);

    localparam logic signed [Z_WIDTH-1:0] ATAN = atan_q28(STEP);

    logic                       r_vld;
    logic signed [XY_WIDTH-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_WIDTH-1:0]  r_z, n_z;
    logic                       r_neg;
    t_in_beat                   r_beat;
    logic signed [XY_WIDTH-1:0] dx, dy;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!i_z[Z_WIDTH-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_neg  <= i_neg;
            r_beat <= i_beat;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_neg  = r_neg;
    assign o_beat = r_beat;

endmodule

// ----- hdl/avr_sincos.sv -----
// ----------------------------------------------------------------------------
// avr_sincos: angle reduction followed by an unrolled CORDIC pipeline
// Folds the angle into [-pi/2, pi/2] with a negate flag, then runs one
// registered CORDIC stage per iteration.
// ----------------------------------------------------------------------------
module avr_sincos
    import avr_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  t_in_beat                   i_beat,
    output logic                       o_vld,
    output logic signed [XY_WIDTH-1:0] o_cos,
    output logic signed [XY_WIDTH-1:0] o_sin,
    output logic                       o_neg,
    output t_in_beat                   o_beat
);

    localparam int NSTG = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

    logic                       vld  [0:NSTG];
    logic signed [XY_WIDTH-1:0] xs   [0:NSTG];
    logic signed [XY_WIDTH-1:0] ys   [0:NSTG];
    logic signed [Z_WIDTH-1:0]  zs   [0:NSTG];
    logic                       negs [0:NSTG];
    t_in_beat                   beats[0:NSTG];

    logic                 r_vld, r_neg, n_neg;
    logic signed [33:0]   r_a, n_a, a_wide, a_fold;
    t_in_beat             r_beat;

    // Full-turn fold, then half-turn fold with a sign flip.
    always_comb begin
        a_wide = 34'(i_beat.turn_angle);
        if (a_wide > PI_Q28) begin
            a_fold = a_wide - TWO_PI_Q28;
        end else if (a_wide < -PI_Q28) begin
            a_fold = a_wide + TWO_PI_Q28;
        end else begin
            a_fold = a_wide;
        end
        n_neg = 1'b1;
        if (a_fold > HALF_PI_Q28) begin
            n_a = a_fold - PI_Q28;
        end else if (a_fold < -HALF_PI_Q28) begin
            n_a = a_fold + PI_Q28;
        end else begin
            n_a   = a_fold;
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_neg  <= n_neg;
            r_beat <= i_beat;
        end
    end

    assign vld[0]   = r_vld;
    assign xs[0]    = GAIN_Q30;
    assign ys[0]    = '0;
    assign zs[0]    = r_a[Z_WIDTH-1:0];
    assign negs[0]  = r_neg;
    assign beats[0] = r_beat;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        avr_cordic_stage #(.STEP(k)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (vld[k]),
            .i_x    (xs[k]),
            .i_y    (ys[k]),
            .i_z    (zs[k]),
            .i_neg  (negs[k]),
            .i_beat (beats[k]),
            .o_vld  (vld[k+1]),
            .o_x    (xs[k+1]),
            .o_y    (ys[k+1]),
            .o_z    (zs[k+1]),
            .o_neg  (negs[k+1]),
            .o_beat (beats[k+1])
        );
    end

    assign o_vld  = vld[NSTG];
    assign o_cos  = xs[NSTG];
    assign o_sin  = ys[NSTG];
    assign o_neg  = negs[NSTG];
    assign o_beat = beats[NSTG];

endmodule

// ----- hdl/avr_rotate.sv -----
// ----------------------------------------------------------------------------
// avr_rotate: applies sine and cosine to the selected coordinate pair
// Four stages: clamp and operand select, partial products, rounding,
// then sum with saturation into the output register.
// ----------------------------------------------------------------------------
module avr_rotate
    import avr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [XY_WIDTH-1:0] i_cos,
    input  logic signed [XY_WIDTH-1:0] i_sin,
    input  logic                       i_neg,
    input  t_in_beat                   i_beat,
    output logic                       o_vld,
    output t_out_beat                  o_beat
);

    localparam int W  = COORD_WIDTH;
    localparam int HW = W + 17;     // p * high half of coefficient
    localparam int LW = W + 16;     // p * low half of coefficient
    localparam int PW = W + 18;     // working width of a rounded product
    localparam int SW = W + 4;      // sum of two rounded products

    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    // ---------------- stage 1: clamp and select ----------------
    logic signed [XY_WIDTH-1:0] c_neg, s_neg, c_cl, s_cl;
    logic signed [W-1:0]        n_u, n_v;

    function automatic logic signed [XY_WIDTH-1:0] clamp1(
        input logic signed [XY_WIDTH-1:0] v
    );
        logic signed [XY_WIDTH-1:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        c_neg = i_neg ? -i_cos : i_cos;
        s_neg = i_neg ? -i_sin : i_sin;
        c_cl  = clamp1(c_neg);
        s_cl  = clamp1(s_neg);
        case (t_axis'(i_beat.req_type))
            AXIS_X: begin
                n_u = i_beat.coord_y;
                n_v = i_beat.coord_z;
            end
            AXIS_Y: begin
                n_u = i_beat.coord_x;
                n_v = i_beat.coord_z;
            end
            default: begin
                n_u = i_beat.coord_x;
                n_v = i_beat.coord_y;
            end
        endcase
    end

    logic                v1;
    logic signed [W-1:0] r1_u, r1_v;
    logic signed [16:0]  r1_ch, r1_sh;
    logic [14:0]         r1_cl, r1_sl;
    t_in_beat            r1_beat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u    <= n_u;
            r1_v    <= n_v;
            r1_ch   <= c_cl[31:15];
            r1_cl   <= c_cl[14:0];
            r1_sh   <= s_cl[31:15];
            r1_sl   <= s_cl[14:0];
            r1_beat <= i_beat;
        end
    end

    // ---------------- stage 2: partial products ----------------
    // Order: u*c, v*s, u*s, v*c.
    logic signed [HW-1:0] r2_hi [0:3];
    logic signed [LW-1:0] r2_lo [0:3];
    logic                 v2;
    t_in_beat             r2_beat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hi[0] <= HW'(r1_u) * HW'(r1_ch);
            r2_lo[0] <= LW'(r1_u) * $signed(LW'({1'b0, r1_cl}));
            r2_hi[1] <= HW'(r1_v) * HW'(r1_sh);
            r2_lo[1] <= LW'(r1_v) * $signed(LW'({1'b0, r1_sl}));
            r2_hi[2] <= HW'(r1_u) * HW'(r1_sh);
            r2_lo[2] <= LW'(r1_u) * $signed(LW'({1'b0, r1_sl}));
            r2_hi[3] <= HW'(r1_v) * HW'(r1_ch);
            r2_lo[3] <= LW'(r1_v) * $signed(LW'({1'b0, r1_cl}));
            r2_beat  <= r1_beat;
        end
    end

    // ---------------- stage 3: rounding ----------------
    logic signed [PW-1:0] rnd [0:3];
    logic signed [SW-1:0] r3_p [0:3];
    logic                 v3;
    t_in_beat             r3_beat;

    for (genvar k = 0; k < 4; k++) begin : g_rnd
        always_comb begin
            rnd[k] = (PW'(r2_hi[k])
                      + ((PW'(r2_lo[k]) + (PW'(1) <<< 29)) >>> 15)) >>> 15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r3_p[k] <= rnd[k][SW-1:0];
            end
            r3_beat <= r2_beat;
        end
    end

    // ---------------- stage 4: sum, saturate, place ----------------
    logic signed [SW-1:0] sum_u, sum_v;
    logic signed [W-1:0]  sat_u, sat_v;
    t_out_beat            n_out, r_out;
    logic                 v4;

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[W-1:0];
    endfunction

    always_comb begin
        sum_u = r3_p[0] - r3_p[1];
        sum_v = r3_p[2] + r3_p[3];
        sat_u = sat(sum_u);
        sat_v = sat(sum_v);
        n_out.rot_x = r3_beat.coord_x;
        n_out.rot_y = r3_beat.coord_y;
        n_out.rot_z = r3_beat.coord_z;
        case (t_axis'(r3_beat.req_type))
            AXIS_X: begin
                n_out.rot_y = sat_u;
                n_out.rot_z = sat_v;
            end
            AXIS_Y: begin
                n_out.rot_x = sat_u;
                n_out.rot_z = sat_v;
            end
            AXIS_Z: begin
                n_out.rot_x = sat_u;
                n_out.rot_y = sat_v;
            end
            default: begin
                n_out.rot_x = r3_beat.coord_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v1 <= 1'b0;
            v2 <= 1'b0;
            v3 <= 1'b0;
            v4 <= 1'b0;
        end else if (i_en) begin
            v1 <= i_vld;
            v2 <= v1;
            v3 <= v2;
            v4 <= v3;
        end
    end

    assign o_vld  = v4;
    assign o_beat = r_out;

endmodule

// ----- hdl/axis_vector_rotation_unit.sv -----
// Throughput: one beat per cycle; every stage is registered and the whole
// pipeline advances together whenever the output register is empty or taken.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// axis_vector_rotation_unit: rotates a 3D point about the X, Y or Z axis
// Angle reduction, an unrolled CORDIC for sine and cosine, then a
// multiply, round and saturate pipeline.
// ----------------------------------------------------------------------------
module axis_vector_rotation_unit
    import avr_pkg::*;
#(
    parameter int CORDIC_STEPS_P = CORDIC_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic                       en;
    logic                       sc_vld, sc_neg;
    logic signed [XY_WIDTH-1:0] sc_cos, sc_sin;
    t_in_beat                   sc_beat;

    // The pipeline moves when the output register can take a new beat.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    avr_sincos #(.STEPS(CORDIC_STEPS_P)) u_sincos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_in_valid),
        .i_beat (i_in_beat),
        .o_vld  (sc_vld),
        .o_cos  (sc_cos),
        .o_sin  (sc_sin),
        .o_neg  (sc_neg),
        .o_beat (sc_beat)
    );

    avr_rotate u_rotate (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (sc_vld),
        .i_cos  (sc_cos),
        .i_sin  (sc_sin),
        .i_neg  (sc_neg),
        .i_beat (sc_beat),
        .o_vld  (o_out_valid),
        .o_beat (o_out_beat)
    );

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result was lost or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

// ----- tb/tb_axis_vector_rotation_unit.sv -----
// ----------------------------------------------------------------------------
// tb_axis_vector_rotation_unit: self-checking bench for the rotation unit
// Drives points, angles and axis selectors through the input stream, predicts
// each rotated point with a bit-exact CORDIC model and compares every output
// beat in order against the queue of predicted points.
// ----------------------------------------------------------------------------
module tb_axis_vector_rotation_unit;
    import avr_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_beat;

    t_out_beat rotated_q[$];
    int        mismatches;
    bit        sink_idle_on;
    bit        src_idle_on;

    localparam longint ANG_PI      = 843314857;
    localparam longint ANG_TWO_PI  = 1686629713;
    localparam longint ANG_HALF_PI = 421657428;
    localparam longint UNIT_Q30    = 1073741824;

    longint arctan_q28[30] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    axis_vector_rotation_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // >>> on longint is arithmetic, so it rounds toward minus infinity.
    function automatic longint times_q30(longint p, longint c);
        longint ch;
        longint cl;
        ch = c >>> 15;
        cl = c & 64'h7fff;
        return ((p * ch) + (((p * cl) + (64'sd1 <<< 29)) >>> 15)) >>> 15;
    endfunction

    function automatic void cordic_sin_cos(input longint ang, output longint c,
                                           output longint s);
        longint cx;
        longint sy;
        longint res;
        longint dx;
        longint dy;
        bit     flip;
        cx = 652032874;
        sy = 0;
        flip = 0;
        if (ang > ANG_PI) ang -= ANG_TWO_PI;
        else if (ang < -ANG_PI) ang += ANG_TWO_PI;
        if (ang > ANG_HALF_PI) begin
            ang -= ANG_PI;
            flip = 1;
        end else if (ang < -ANG_HALF_PI) begin
            ang += ANG_PI;
            flip = 1;
        end
        res = ang;
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (res >= 0) begin
                cx -= dx;
                sy += dy;
                res -= arctan_q28[i];
            end else begin
                cx += dx;
                sy -= dy;
                res += arctan_q28[i];
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        c = clip(cx, -UNIT_Q30, UNIT_Q30);
        s = clip(sy, -UNIT_Q30, UNIT_Q30);
    endfunction

    function automatic void rotate_pair(inout longint u, inout longint v,
                                        input longint c, input longint s);
        longint a;
        longint b;
        a = u;
        b = v;
        u = clip(times_q30(a, c) - times_q30(b, s), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        v = clip(times_q30(a, s) + times_q30(b, c), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    endfunction

    function automatic t_out_beat rotate_point(t_in_beat b);
        longint    px;
        longint    py;
        longint    pz;
        longint    c;
        longint    s;
        t_out_beat r;
        px = b.coord_x;
        py = b.coord_y;
        pz = b.coord_z;
        cordic_sin_cos(longint'(b.turn_angle), c, s);
        case (t_axis'(b.req_type))
            AXIS_X: rotate_pair(py, pz, c, s);
            AXIS_Y: rotate_pair(px, pz, c, s);
            AXIS_Z: rotate_pair(px, py, c, s);
            default: ;
        endcase
        r.rot_x = px[31:0];
        r.rot_y = py[31:0];
        r.rot_z = pz[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // Sends one beat; valid stays high across back-to-back beats.
    task automatic send_point(t_axis ax, int x, int y, int z, int ang);
        while (src_idle_on && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat.req_type   <= ax;
        i_in_beat.coord_x    <= x;
        i_in_beat.coord_y    <= y;
        i_in_beat.coord_z    <= z;
        i_in_beat.turn_angle <= ang;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rotated_q.push_back(rotate_point({2'(ax), 32'(x), 32'(y), 32'(z), 32'(ang)}));
        @(negedge i_clk);
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Output checker and sink stall generator.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected beat", o_out_beat.rot_x, '0);
            end else begin
                t_out_beat want;
                want = rotated_q.pop_front();
                if (o_out_beat.rot_x !== want.rot_x)
                    report_mismatch("rot_x", o_out_beat.rot_x, want.rot_x);
                if (o_out_beat.rot_y !== want.rot_y)
                    report_mismatch("rot_y", o_out_beat.rot_y, want.rot_y);
                if (o_out_beat.rot_z !== want.rot_z)
                    report_mismatch("rot_z", o_out_beat.rot_z, want.rot_z);
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !(sink_idle_on && $urandom_range(99) < 30);
    end

    task automatic test_directed();
        int ext[6] = '{32'h8000_0000, 32'h7fff_ffff, 0, -1, 32'h0001_0000, -32'sh1_0000};
        send_point(AXIS_X, 1, 2, 3, 0);
        send_point(AXIS_Y, 65536, 0, 65536, int'(ANG_PI));
        send_point(AXIS_Z, 65536, 65536, 0, int'(-ANG_PI));
        send_point(AXIS_X, 0, 65536, 0, int'(ANG_HALF_PI));
        send_point(AXIS_Y, 65536, 5, 0, int'(ANG_HALF_PI + 1));
        send_point(AXIS_Z, 65536, 0, 7, int'(-ANG_HALF_PI - 1));
        send_point(AXIS_X, 3, 65536, -65536, int'(ANG_PI + 1));
        send_point(AXIS_Z, -65536, 65536, 9, int'(-ANG_PI - 1));
        send_point(AXIS_NONE, 11, -12, 13, 12345678);
        send_point(AXIS_X, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(AXIS_Y, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // Forty-five degrees on full-scale values pushes the sums past the range.
        send_point(AXIS_Z, 32'h7fff_ffff, 32'h7fff_ffff, 0, 210828714);
        send_point(AXIS_X, 0, 32'h8000_0000, 32'h8000_0000, 210828714);
        send_point(AXIS_Y, 32'h8000_0000, 0, 32'h7fff_ffff, -210828714);
        for (int i = 0; i < 6; i++)
            send_point(t_axis'(i % 4), ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 3) % 6]);
        go_quiet();
    endtask

    task automatic test_random(int count);
        int ang;
        for (int i = 0; i < count; i++) begin
            // Stretch at the start with both sides running flat out.
            src_idle_on  = (i >= 150);
            sink_idle_on = (i >= 150);
            case ($urandom_range(3))
                0: ang = $urandom;
                default: ang = $urandom_range(2 * ANG_PI) - ANG_PI;
            endcase
            if ($urandom_range(9) == 0)
                send_point(t_axis'($urandom_range(3)), $urandom, $urandom, $urandom, ang);
            else
                send_point(t_axis'($urandom_range(3)), $signed($urandom) >>> $urandom_range(20),
                           $signed($urandom) >>> $urandom_range(20),
                           $signed($urandom) >>> $urandom_range(20), ang);
        end
        go_quiet();
    endtask

    initial begin
        int waited;
        mismatches   = 0;
        sink_idle_on = 1;
        src_idle_on  = 1;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_beat    = '0;
        i_out_ready  = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(1100);
        waited = 0;
        while (rotated_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (CORDIC_STEPS + 20) @(posedge i_clk);
        if (mismatches == 0 && rotated_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
